/* sv/fpu_pkg.sv */
// Shared types, codes and constants of the binary32 arithmetic unit.
package fpu_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_FMA = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        RM_RNE = 2'd0,
        RM_RUP = 2'd1,
        RM_RDN = 2'd2,
        RM_RTZ = 2'd3
    } t_rm;

    typedef enum logic [1:0] {
        CFG_NAN_SCHEME  = 2'd0,
        CFG_DEFAULT_NAN = 2'd1,
        CFG_FMA_ZI_INV  = 2'd2
    } t_cfg_idx;

    localparam logic [31:0] DEFAULT_NAN_RST = 32'h7fc00000;
    localparam logic [31:0] POS_INF         = 32'h7f800000;
    localparam logic [31:0] MAX_FINITE      = 32'h7f7fffff;
    localparam logic [31:0] QUIET_BIT       = 32'h00400000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  rounding_mode;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
        logic [31:0] operand_c;
    } t_in;

    typedef struct packed {
        logic [31:0] result;
        logic        flag_invalid;
        logic        flag_overflow;
        logic        flag_underflow;
        logic        flag_inexact;
    } t_out;

    // Signed exponents: 11 bits cover every intermediate value.
    typedef logic signed [10:0] t_exp;

    // Special-case outcome, resolved in the first stage.
    typedef struct packed {
        logic        special;
        logic [31:0] value;
        logic        invalid;
    } t_spec;

    // Terms aligned for the adder, handed from alignment stage to add stage.
    typedef struct packed {
        logic        valid;
        t_rm         rm;
        t_spec       spec;
        logic        s1;
        logic [63:0] m1;
        logic        s2;
        logic [63:0] m2;
        t_exp        e;
    } t_sum_in;

    function automatic logic f_is_nan(logic [31:0] x);
        return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_snan(logic [31:0] x);
        return f_is_nan(x) && !x[22];
    endfunction

    function automatic logic f_is_inf(logic [31:0] x);
        return x[30:0] == POS_INF[30:0];
    endfunction

    function automatic logic f_is_zero(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] f_mant(logic [31:0] x);
        return {x[30:23] != 8'd0, x[22:0]};
    endfunction

    function automatic t_exp f_exp(logic [31:0] x);
        t_exp e;
        e = (x[30:23] == 8'd0) ? t_exp'(1) : t_exp'({3'd0, x[30:23]});
        return e - t_exp'(150);
    endfunction

    function automatic logic [5:0] f_lzc64(logic [63:0] v);
        logic [5:0] n;
        n = 6'd63;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 6'(63 - i);
        end
        return n;
    endfunction

endpackage

/* sv/fpu_round.sv */
// Normalize, round and pack stages of the binary32 unit.
module fpu_round (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  fpu_pkg::t_rm         i_rm,
    input  fpu_pkg::t_spec       i_spec,
    input  logic                 i_sign,
    input  logic                 i_zero,
    input  logic [63:0]          i_sig,
    input  fpu_pkg::t_exp        i_exp,
    output logic                 o_valid,
    output fpu_pkg::t_out        o_res
);
    import fpu_pkg::*;

    // Stage A: normalize so bit 62 is set.
    logic        r_a_valid, r_a_sign, r_a_zero;
    t_rm         r_a_rm;
    t_spec       r_a_spec;
    logic [62:0] r_a_sig;
    t_exp        r_a_x;
    logic [5:0]  lz;

    assign lz = f_lzc64(i_sig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_rm   <= i_rm;
        r_a_spec <= i_spec;
        r_a_sign <= i_sign;
        r_a_zero <= i_zero;
        // lz counts from bit 63; bit 62 target means one less shift.
        r_a_sig  <= 63'(i_sig << (lz - 6'd1));
        r_a_x    <= i_exp + t_exp'(63) - t_exp'({5'd0, lz});
    end

    // Stage B: choose rounding position, compute tininess.
    function automatic logic f_rup(logic lsb, logic g, logic st, logic s, t_rm rm);
        case (rm)
            RM_RNE:  return g && (st || lsb);
            RM_RUP:  return (g || st) && !s;
            RM_RDN:  return (g || st) && s;
            default: return 1'b0;
        endcase
    endfunction

    logic        n_b_tiny;
    logic [6:0]  n_b_shift;
    t_exp        be;
    logic [23:0] q0;
    logic        inc0;
    logic [62:0] sig_n;

    always_comb begin
        // sig_n has bit 62 set (when not zero); pre-shift sits at bit 39.
        sig_n = r_a_sig;
        q0    = sig_n[62:39];
        inc0  = f_rup(q0[0], sig_n[38], sig_n[37:0] != 38'd0, r_a_sign, r_a_rm);
        if (inc0 && (q0 == 24'hffffff)) n_b_tiny = (r_a_x + t_exp'(1)) < t_exp'(-126);
        else n_b_tiny = r_a_x < t_exp'(-126);
        be = r_a_x + t_exp'(127);
        if (be >= t_exp'(1))       n_b_shift = 7'd39;
        else if (be < t_exp'(-23)) n_b_shift = 7'd64;
        else                       n_b_shift = 7'(t_exp'(40) - be);
    end

    logic        r_b_valid, r_b_sign, r_b_zero, r_b_tiny;
    t_rm         r_b_rm;
    t_spec       r_b_spec;
    t_exp        r_b_be;
    logic [24:0] r_b_q;
    logic        r_b_g, r_b_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_rm   <= r_a_rm;
        r_b_spec <= r_a_spec;
        r_b_sign <= r_a_sign;
        r_b_zero <= r_a_zero;
        r_b_tiny <= n_b_tiny;
        r_b_be   <= be;
        if (n_b_shift == 7'd64) begin
            // Far below the smallest subnormal: only a sticky bit survives.
            r_b_q  <= 25'd0;
            r_b_g  <= 1'b0;
            r_b_st <= 1'b1;
        end else begin
            r_b_q  <= 25'({1'b0, sig_n} >> n_b_shift);
            r_b_g  <= sig_n[6'(n_b_shift - 7'd1)];
            r_b_st <= ((sig_n << (7'd64 - n_b_shift)) & {63{1'b1}}) != 63'd0
                      && n_b_shift > 7'd1;
        end
    end

    // Stage C: increment, overflow, pack.
    t_out        n_res;
    logic [24:0] q;
    logic        inx;
    t_exp        bef;
    logic [30:0] big;

    always_comb begin
        inx  = r_b_g || r_b_st;
        q    = r_b_q + 25'(f_rup(r_b_q[0], r_b_g, r_b_st, r_b_sign, r_b_rm));
        bef  = r_b_be;
        n_res = '0;
        n_res.flag_inexact   = inx;
        n_res.flag_underflow = r_b_tiny && inx;
        case (r_b_rm)
            RM_RNE:  big = POS_INF[30:0];
            RM_RUP:  big = r_b_sign ? MAX_FINITE[30:0] : POS_INF[30:0];
            RM_RDN:  big = r_b_sign ? POS_INF[30:0] : MAX_FINITE[30:0];
            default: big = MAX_FINITE[30:0];
        endcase
        if (r_b_be >= t_exp'(1)) begin
            if (q[24]) begin
                q   = q >> 1;
                bef = r_b_be + t_exp'(1);
            end
            if (bef >= t_exp'(255)) begin
                n_res.flag_overflow = 1'b1;
                n_res.flag_inexact  = 1'b1;
                n_res.result        = {r_b_sign, big};
            end else begin
                n_res.result = {r_b_sign, bef[7:0], q[22:0]};
            end
        end else begin
            n_res.result = {r_b_sign, 7'd0, q[23:0]};
        end
        if (r_b_zero) begin
            n_res = '0;
            n_res.result = {r_b_rm == RM_RDN, 31'd0};
        end
        if (r_b_spec.special) begin
            n_res = '0;
            n_res.result       = r_b_spec.value;
            n_res.flag_invalid = r_b_spec.invalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_b_valid;
        end
        o_res <= n_res;
    end

endmodule

/* sv/fp32_add_sub_mul_fma_unit.sv */
// Top level of the pipelined binary32 add / subtract / multiply / FMA unit.
//
// Usage:
//   Drive i_start with an operation beat on i_in; it is taken at the edge
//   where i_start is high and o_busy is low. o_busy is tied low: the pipe
//   accepts one beat every cycle with no stall.
//   Each result beat appears on o_out for exactly one cycle, marked by
//   o_done. Results leave in issue order.
//   The receiver cannot hold results off; nothing here waits on it.
//   Stages: 1 special cases and mantissa product, 2 alignment,
//   3 add and magnitude compare, 4 normalize, 5 rounding position and
//   tininess, 6 increment, overflow and pack into the output register.
//   Throughput is one beat per cycle; the pipe has six register stages,
//   as the product, alignment and normalize shifter each take a stage.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write nan_scheme,
//   default_nan and fma_zero_inf_invalid; write them only while idle.
//   Reset (synchronous, active low) drops all in-flight beats and restores
//   default configuration: canonical NaN 0x7fc00000, invalid on FMA zero
//   times infinity.
module fp32_add_sub_mul_fma_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  fpu_pkg::t_in  i_in,
    output logic          o_done,
    output fpu_pkg::t_out o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import fpu_pkg::*;

    logic        r_nan_scheme, r_fma_zi_inv;
    logic [31:0] r_default_nan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nan_scheme  <= 1'b0;
            r_default_nan <= DEFAULT_NAN_RST;
            r_fma_zi_inv  <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NAN_SCHEME:  r_nan_scheme  <= i_cfg_data[0];
                CFG_DEFAULT_NAN: r_default_nan <= i_cfg_data;
                CFG_FMA_ZI_INV:  r_fma_zi_inv  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // ---- Stage 1: special cases, product, operand setup.
    logic [31:0] a, b, c, bx;
    t_op         op;
    t_spec       n_spec;
    logic        sp, is_fma, is_mul, add_only;

    function automatic logic [31:0] f_pick(logic sch, logic [31:0] dn, logic [31:0] x,
                                            logic [31:0] y, logic [31:0] z, logic use_z);
        if (!sch) return dn;
        if (f_is_nan(x)) return x | QUIET_BIT;
        if (f_is_nan(y) || !use_z) return y | QUIET_BIT;
        return z | QUIET_BIT;
    endfunction

    always_comb begin
        a  = i_in.operand_a;
        b  = i_in.operand_b;
        c  = i_in.operand_c;
        op = t_op'(i_in.operation);
        bx = (op == OP_SUB) ? {~b[31], b[30:0]} : b;
        sp = a[31] ^ b[31];
        is_fma = op == OP_FMA;
        is_mul = op == OP_MUL;
        add_only = !is_fma && !is_mul;
        n_spec = '0;
        if (add_only) begin
            if (f_is_nan(a) || f_is_nan(b)) begin
                n_spec = '{1'b1, f_pick(r_nan_scheme, r_default_nan, a, b, 32'd0, 1'b0),
                           f_is_snan(a) || f_is_snan(b)};
            end else if (f_is_inf(a) || f_is_inf(bx)) begin
                if (f_is_inf(a) && f_is_inf(bx) && a[31] != bx[31])
                    n_spec = '{1'b1, r_default_nan, 1'b1};
                else
                    n_spec = '{1'b1, f_is_inf(a) ? a : bx, 1'b0};
            end else if (f_is_zero(a) && f_is_zero(bx)) begin
                n_spec = '{1'b1, {(a[31] == bx[31]) ? a[31]
                           : (i_in.rounding_mode == RM_RDN), 31'd0}, 1'b0};
            end else if (f_is_zero(a)) begin
                n_spec = '{1'b1, bx, 1'b0};
            end else if (f_is_zero(bx)) begin
                n_spec = '{1'b1, a, 1'b0};
            end
        end else if (is_mul) begin
            if (f_is_nan(a) || f_is_nan(b)) begin
                n_spec = '{1'b1, f_pick(r_nan_scheme, r_default_nan, a, b, 32'd0, 1'b0),
                           f_is_snan(a) || f_is_snan(b)};
            end else if (f_is_inf(a) || f_is_inf(b)) begin
                if (f_is_zero(a) || f_is_zero(b)) n_spec = '{1'b1, r_default_nan, 1'b1};
                else n_spec = '{1'b1, {sp, POS_INF[30:0]}, 1'b0};
            end else if (f_is_zero(a) || f_is_zero(b)) begin
                n_spec = '{1'b1, {sp, 31'd0}, 1'b0};
            end
        end else begin
            if (f_is_nan(a) || f_is_nan(b) || f_is_nan(c)) begin
                n_spec = '{1'b1, f_pick(r_nan_scheme, r_default_nan, a, b, c, 1'b1),
                           f_is_snan(a) || f_is_snan(b) || f_is_snan(c) ||
                           (r_fma_zi_inv && ((f_is_zero(a) && f_is_inf(b)) ||
                                             (f_is_zero(b) && f_is_inf(a))))};
            end else if (f_is_inf(a) || f_is_inf(b)) begin
                if (f_is_zero(a) || f_is_zero(b) || (f_is_inf(c) && c[31] != sp))
                    n_spec = '{1'b1, r_default_nan, 1'b1};
                else n_spec = '{1'b1, {sp, POS_INF[30:0]}, 1'b0};
            end else if (f_is_inf(c)) begin
                n_spec = '{1'b1, c, 1'b0};
            end else if (f_is_zero(a) || f_is_zero(b)) begin
                if (f_is_zero(c))
                    n_spec = '{1'b1, {(sp == c[31]) ? sp
                               : (i_in.rounding_mode == RM_RDN), 31'd0}, 1'b0};
                else n_spec = '{1'b1, c, 1'b0};
            end
        end
    end

    // Term 1 is a or the product; term 2 is b or c, absent for multiply or a zero FMA addend.
    logic        r1_valid, r1_s1, r1_s2, r1_t2;
    t_rm         r1_rm;
    t_spec       r1_spec;
    logic [47:0] r1_m1;
    logic [23:0] r1_m2;
    t_exp        r1_e1, r1_e2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
        end
        r1_rm   <= t_rm'(i_in.rounding_mode);
        r1_spec <= n_spec;
        if (add_only) begin
            r1_s1 <= a[31];
            r1_m1 <= {24'd0, f_mant(a)};
            r1_e1 <= f_exp(a);
            r1_s2 <= bx[31];
            r1_m2 <= f_mant(bx);
            r1_e2 <= f_exp(bx);
            r1_t2 <= 1'b1;
        end else begin
            r1_s1 <= sp;
            r1_m1 <= f_mant(a) * f_mant(b);
            r1_e1 <= f_exp(a) + f_exp(b);
            r1_s2 <= c[31];
            r1_m2 <= f_mant(c);
            r1_e2 <= f_exp(c);
            r1_t2 <= is_fma && !f_is_zero(c);
        end
    end

    // ---- Stage 2: when term 2 is present, normalize both terms to bit 60 and align the smaller.
    logic [63:0] m1n, m2n, big_m, sml_m, sml_sh;
    t_exp        e1n, e2n, d;
    logic        swap;
    logic [5:0]  lz1, lz2;

    always_comb begin
        lz1 = f_lzc64({16'd0, r1_m1});
        lz2 = f_lzc64({40'd0, r1_m2});
        m1n = {16'd0, r1_m1} << (lz1 - 6'd3);
        m2n = {40'd0, r1_m2} << (lz2 - 6'd3);
        e1n = r1_e1 - t_exp'({5'd0, lz1}) + t_exp'(3);
        e2n = r1_e2 - t_exp'({5'd0, lz2}) + t_exp'(3);
        swap  = e1n < e2n;
        big_m = swap ? m2n : m1n;
        sml_m = swap ? m1n : m2n;
        d     = swap ? (e2n - e1n) : (e1n - e2n);
        if (d >= t_exp'(62)) sml_sh = 64'd1;
        else sml_sh = (sml_m >> d[5:0]) |
                      64'(((sml_m & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0));
    end

    t_sum_in r2;
    logic    r2_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2.valid <= 1'b0;
        end else begin
            r2.valid <= r1_valid;
        end
        r2.rm   <= r1_rm;
        r2.spec <= r1_spec;
        r2_t2   <= r1_t2;
        if (r1_t2) begin
            r2.s1 <= swap ? r1_s2 : r1_s1;
            r2.s2 <= swap ? r1_s1 : r1_s2;
            r2.m1 <= big_m;
            r2.m2 <= sml_sh;
            r2.e  <= swap ? e2n : e1n;
        end else begin
            r2.s1 <= r1_s1;
            r2.s2 <= r1_s1;
            r2.m1 <= {16'd0, r1_m1};
            r2.m2 <= 64'd0;
            r2.e  <= r1_e1;
        end
    end

    // ---- Stage 3: add or subtract magnitudes.
    logic [63:0] sum;
    logic        ssign;

    always_comb begin
        if (r2.s1 == r2.s2) begin
            sum = r2.m1 + r2.m2;  ssign = r2.s1;
        end else if (r2.m1 >= r2.m2) begin
            sum = r2.m1 - r2.m2;  ssign = r2.s1;
        end else begin
            sum = r2.m2 - r2.m1;  ssign = r2.s2;
        end
    end

    logic        r3_valid, r3_sign, r3_zero;
    t_rm         r3_rm;
    t_spec       r3_spec;
    logic [63:0] r3_sig;
    t_exp        r3_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2.valid;
        end
        r3_rm   <= r2.rm;
        r3_spec <= r2.spec;
        r3_sign <= ssign;
        r3_zero <= (sum == 64'd0) && r2_t2;
        r3_sig  <= (sum == 64'd0) ? 64'd1 : sum;
        r3_e    <= r2.e;
    end

    fpu_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_rm    (r3_rm),
        .i_spec  (r3_spec),
        .i_sign  (r3_sign),
        .i_zero  (r3_zero),
        .i_sig   (r3_sig),
        .i_exp   (r3_e),
        .o_valid (o_done),
        .o_res   (o_out)
    );

endmodule
